[design/assert_macros.svh]
// Assertion macros shared by the timer list engine RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MTLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MTLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/mtle_pkg.sv]
// Package for the timer list engine: sizes, status codes and the table entry type.
// No dependencies.
package mtle_pkg;

    localparam int MAX_TIMERS_DEF = 16;

    localparam logic [1:0] STATUS_FIRED  = 2'd0;
    localparam logic [1:0] STATUS_ACCEPT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    localparam logic [7:0] REPEAT_FOREVER = 8'hFF;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] timeout;
        logic [7:0]  repeats;
        logic [7:0]  handle;
        logic [31:0] argument;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[design/mtle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mtle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/multi_timer_list_engine_core.sv]
// Timer list engine: insert leaves busy low; result strobed the cycle after acceptance.
// A tick holds busy while it walks the table; the next transaction is taken after busy
// falls. One table read per cycle through the entry RAM, whose registered read data
// lengthens the walk. Fire results appear during the walk; the last one comes with
// busy falling. Synchronous active-low reset empties the table and clears the tick;
// RAM is not cleared.
`include "assert_macros.svh"

module multi_timer_list_engine_core
    import mtle_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [31:0]       i_timeout_ticks,
    input  logic signed [7:0] i_repeat_count,
    input  logic [7:0]        i_callback_id,
    input  logic [31:0]       i_callback_arg,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [7:0]        o_fired_id,
    output logic [31:0]       o_fired_arg,
    output logic              o_last
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_tick, n_tick;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_wr, n_wr;
    logic          r_dv, n_dv;
    logic          r_hold_vld, n_hold_vld;
    logic [7:0]    r_hold_id, n_hold_id;
    logic [31:0]   r_hold_arg, n_hold_arg;
    logic          r_out_vld, n_out_vld;
    logic [1:0]    r_out_status, n_out_status;
    logic [7:0]    r_out_id, n_out_id;
    logic [31:0]   r_out_arg, n_out_arg;
    logic          r_out_last, n_out_last;

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        rd_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    logic          expired;
    logic          keep;
    t_entry        upd_entry;

    mtle_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TIMERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign rd_entry = t_entry'(ram_rdata);
    assign expired  = (r_tick - rd_entry.start) >= rd_entry.timeout;
    assign keep     = !expired || (rd_entry.repeats != 8'd0);

    always_comb begin
        upd_entry = rd_entry;
        if (expired) begin
            upd_entry.start = r_tick;
            if (rd_entry.repeats != REPEAT_FOREVER) begin
                upd_entry.repeats = rd_entry.repeats - 8'd1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_count      = r_count;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_dv         = 1'b0;
        n_hold_vld   = r_hold_vld;
        n_hold_id    = r_hold_id;
        n_hold_arg   = r_hold_arg;
        n_out_vld    = 1'b0;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_arg    = r_out_arg;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_raddr    = r_rd[AW-1:0];
        ram_wdata    = '{start: r_tick, timeout: i_timeout_ticks,
                         repeats: unsigned'(i_repeat_count),
                         handle: i_callback_id, argument: i_callback_arg};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command) begin
                        n_out_vld  = 1'b1;
                        n_out_last = 1'b1;
                        n_out_id   = i_callback_id;
                        n_out_arg  = i_callback_arg;
                        if (r_count >= CW'(MAX_TIMERS)) begin
                            n_out_status = STATUS_FULL;
                        end else begin
                            n_out_status = STATUS_ACCEPT;
                            ram_we       = 1'b1;
                            n_count      = r_count + CW'(1);
                        end
                    end else begin
                        n_tick     = r_tick + 32'd1;
                        n_state    = ST_WALK;
                        n_rd       = '0;
                        n_wr       = '0;
                        n_hold_vld = 1'b0;
                    end
                end
            end
            ST_WALK: begin
                if (r_rd < r_count) begin
                    n_dv = 1'b1;
                    n_rd = r_rd + CW'(1);
                end
                if (r_dv) begin
                    if (expired) begin
                        if (r_hold_vld) begin
                            n_out_vld    = 1'b1;
                            n_out_status = STATUS_FIRED;
                            n_out_id     = r_hold_id;
                            n_out_arg    = r_hold_arg;
                            n_out_last   = 1'b0;
                        end
                        n_hold_vld = 1'b1;
                        n_hold_id  = rd_entry.handle;
                        n_hold_arg = rd_entry.argument;
                    end
                    if (keep) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wr[AW-1:0];
                        ram_wdata = upd_entry;
                        n_wr      = r_wr + CW'(1);
                    end
                end else if (r_rd >= r_count) begin
                    // walk finished: close up the table and flush the held result
                    n_count = r_wr;
                    n_state = ST_IDLE;
                    if (r_hold_vld) begin
                        n_out_vld    = 1'b1;
                        n_out_status = STATUS_FIRED;
                        n_out_id     = r_hold_id;
                        n_out_arg    = r_hold_arg;
                        n_out_last   = 1'b1;
                    end
                    n_hold_vld = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tick     <= '0;
            r_count    <= '0;
            r_rd       <= '0;
            r_wr       <= '0;
            r_dv       <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_count    <= n_count;
            r_rd       <= n_rd;
            r_wr       <= n_wr;
            r_dv       <= n_dv;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_id    <= n_hold_id;
        r_hold_arg   <= n_hold_arg;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_arg    <= n_out_arg;
        r_out_last   <= n_out_last;
    end

    assign o_valid     = r_out_vld;
    assign o_status    = r_out_status;
    assign o_fired_id  = r_out_id;
    assign o_fired_arg = r_out_arg;
    assign o_last      = r_out_last;

    `MTLE_ASSERT_NEXT(a_insert_result, accept && i_command,
        o_valid && o_last && (o_status == STATUS_ACCEPT || o_status == STATUS_FULL),
        "insert transaction gave no single final result")
    `MTLE_ASSERT_NOW(a_midwalk_busy, o_valid && !o_last, busy,
        "non-final result outside a tick walk")
    `MTLE_ASSERT_NOW(a_wr_behind_rd, 1'b1, r_wr <= r_rd,
        "compaction write index overtook read index")
    `MTLE_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_TIMERS),
        "timer count exceeds table size")

endmodule

[tb/sv/mtle_test_pkg.sv]
`timescale 1ns / 1ps
// Command codes shared by the timer list engine test bench and its checker.
// No dependencies.
package mtle_test_pkg;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

endpackage

[tb/sv/multi_timer_list_engine_checker.sv]
`timescale 1ns / 1ps
// Checker for multi_timer_list_engine_core: keeps its own timer table and tick count,
// predicts the results of each accepted transaction and compares every result strobe.
// Depends on mtle_pkg and mtle_test_pkg.
module multi_timer_list_engine_checker
    import mtle_pkg::*;
    import mtle_test_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_command,
    input  logic [31:0]       i_timeout_ticks,
    input  logic signed [7:0] i_repeat_count,
    input  logic [7:0]        i_callback_id,
    input  logic [31:0]       i_callback_arg,
    input  logic              i_valid,
    input  logic [1:0]        i_status,
    input  logic [7:0]        i_fired_id,
    input  logic [31:0]       i_fired_arg,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  id;
        logic [31:0] arg;
        logic        last;
    } t_timer_result;

    t_timer_result awaited_results[$];
    t_entry        timer_table[MAX_TIMERS];
    logic [31:0]   tick_now;
    int            timer_count;

    task automatic expect_result(input logic [1:0] status, input logic [7:0] id,
                                 input logic [31:0] arg, input logic last);
        t_timer_result res;
        res.status = status;
        res.id     = id;
        res.arg    = arg;
        res.last   = last;
        awaited_results.push_back(res);
    endtask

    task automatic advance_timers(input logic cmd, input logic [31:0] timeout,
                                  input logic [7:0] repeats, input logic [7:0] handle,
                                  input logic [31:0] argument);
        t_entry        ent;
        t_timer_result tail;
        logic [31:0]   elapsed;
        logic          keep;
        int            wr;
        int            fired;
        if (cmd == CMD_INSERT) begin
            if (timer_count >= MAX_TIMERS) begin
                expect_result(STATUS_FULL, handle, argument, 1'b1);
            end else begin
                ent.start    = tick_now;
                ent.timeout  = timeout;
                ent.repeats  = repeats;
                ent.handle   = handle;
                ent.argument = argument;
                timer_table[timer_count] = ent;
                timer_count++;
                expect_result(STATUS_ACCEPT, handle, argument, 1'b1);
            end
        end else begin
            tick_now = tick_now + 32'd1;
            wr = 0;
            fired = 0;
            for (int rd = 0; rd < timer_count; rd++) begin
                ent = timer_table[rd];
                keep = 1'b1;
                elapsed = tick_now - ent.start;
                if (elapsed >= ent.timeout) begin
                    expect_result(STATUS_FIRED, ent.handle, ent.argument, 1'b0);
                    fired++;
                    if (ent.repeats == 8'd0) begin
                        keep = 1'b0;
                    end else begin
                        if (ent.repeats != REPEAT_FOREVER)
                            ent.repeats = ent.repeats - 8'd1;
                        ent.start = tick_now;
                    end
                end
                if (keep) begin
                    timer_table[wr] = ent;
                    wr++;
                end
            end
            timer_count = wr;
            if (fired > 0) begin
                tail = awaited_results.pop_back();
                tail.last = 1'b1;
                awaited_results.push_back(tail);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input t_timer_result want,
                                   input t_timer_result got);
        if (o_errors < 10)
            $display("%0t: %s: exp status=%0d id=%h arg=%h last=%0d, got status=%0d id=%h arg=%h last=%0d",
                     $realtime, what, want.status, want.id, want.arg, want.last,
                     got.status, got.id, got.arg, got.last);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            tick_now = 32'd0;
            timer_count = 0;
            awaited_results.delete();
        end else begin
            if (i_start && !i_busy)
                advance_timers(i_command, i_timeout_ticks, i_repeat_count,
                               i_callback_id, i_callback_arg);
            if (i_valid) begin
                got.status = i_status;
                got.id     = i_fired_id;
                got.arg    = i_fired_arg;
                got.last   = i_last;
                if (awaited_results.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected result", want, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.id !== want.id ||
                        got.arg !== want.arg || got.last !== want.last)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

[tb/sv/multi_timer_list_engine_core_test.sv]
`timescale 1ns / 1ps
// Top of the timer list engine test: clock, reset, directed and random transactions.
// Depends on mtle_pkg, mtle_test_pkg, multi_timer_list_engine_checker and the core.
module multi_timer_list_engine_core_test
    import mtle_test_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_TAIL   = 25;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              i_command = CMD_TICK;
    logic [31:0]       i_timeout_ticks = '0;
    logic signed [7:0] i_repeat_count = '0;
    logic [7:0]        i_callback_id = '0;
    logic [31:0]       i_callback_arg = '0;
    logic              busy;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [7:0]        o_fired_id;
    logic [31:0]       o_fired_arg;
    logic              o_last;

    int                check_errors;
    int                check_pending;
    int                cycles = 0;
    logic              gaps_on = 1'b1;

    always #4 i_clk = ~i_clk;

    multi_timer_list_engine_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_timeout_ticks (i_timeout_ticks),
        .i_repeat_count  (i_repeat_count),
        .i_callback_id   (i_callback_id),
        .i_callback_arg  (i_callback_arg),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_fired_id      (o_fired_id),
        .o_fired_arg     (o_fired_arg),
        .o_last          (o_last)
    );

    multi_timer_list_engine_checker check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_command       (i_command),
        .i_timeout_ticks (i_timeout_ticks),
        .i_repeat_count  (i_repeat_count),
        .i_callback_id   (i_callback_id),
        .i_callback_arg  (i_callback_arg),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_fired_id      (o_fired_id),
        .i_fired_arg     (o_fired_arg),
        .i_last          (o_last),
        .o_errors        (check_errors),
        .o_pending       (check_pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("multi_timer_list_engine_core_test NOT OK");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [31:0] timeout,
                             input logic signed [7:0] repeats, input logic [7:0] id,
                             input logic [31:0] arg);
        start           <= 1'b1;
        i_command       <= cmd;
        i_timeout_ticks <= timeout;
        i_repeat_count  <= repeats;
        i_callback_id   <= id;
        i_callback_arg  <= arg;
        do @(posedge i_clk); while (busy);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, $urandom, 8'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (check_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random_item();
        logic [31:0]       timeout;
        logic signed [7:0] repeats;
        int                pick;
        if ($urandom_range(0, 9) < 4) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)      timeout = $urandom;
            else if (pick < 6)  timeout = 32'd0;
            else                timeout = $urandom_range(1, 10);
            pick = $urandom_range(0, 39);
            if (pick == 0)      repeats = -8'sd1;
            else if (pick == 1) repeats = 8'($urandom);
            else                repeats = 8'($urandom_range(0, 3));
            send_item(CMD_INSERT, timeout, repeats, 8'($urandom), $urandom);
        end else begin
            send_tick();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then the special repeat and timeout values
        send_tick();
        send_item(CMD_INSERT, 32'd0, -8'sd1, 8'h00, 32'h0000_0000);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'sd127, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'd1, -8'sd128, 8'h5A, 32'hA5A5_A5A5);
        send_item(CMD_INSERT, 32'd2, -8'sd2, 8'hA5, 32'h5A5A_5A5A);
        send_item(CMD_INSERT, 32'd0, 8'sd0, 8'h01, 32'h0000_0001);
        send_item(CMD_INSERT, 32'd1, 8'sd1, 8'h02, 32'h0000_0002);
        repeat (3) send_tick();
        // fill the table, then one refused insert
        for (int n = 0; n < 12; n++)
            send_item(CMD_INSERT, 32'd4, 8'sd0, 8'h10 + 8'(n), $urandom);
        send_item(CMD_INSERT, $urandom, 8'($urandom), 8'h3C, $urandom);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                gaps_on = 1'b0;
            send_random_item();
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (check_errors == 0 && check_pending == 0) begin
            $display("multi_timer_list_engine_core_test OK");
        end else begin
            $display("multi_timer_list_engine_core_test NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/mtle_pkg.sv
design/mtle_ram.sv
design/multi_timer_list_engine_core.sv
tb/sv/mtle_test_pkg.sv
tb/sv/multi_timer_list_engine_checker.sv
tb/sv/multi_timer_list_engine_core_test.sv
